### rtl/gepc_pkg.sv
package gepc_pkg;

    localparam int MAX_DIM   = 64;
    localparam int MAX_MOVES = 64;

    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int MOVE_W  = $clog2(MAX_MOVES + 1);
    localparam int CNT_W   = 30;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W  = 1 + 2 * IDX_W;

    localparam logic [CNT_W-1:0] PATH_MOD = CNT_W'(1000000007);

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVES = 2'd2;

    // idle cycles between layers so the last writes land before the next reads
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    // one neighbor-pair read issued by the sequencer
    typedef struct packed {
        logic              first;
        logic              second;
        logic              on_a;
        logic              on_b;
        logic              zero_prev;
        logic              hit;
        logic [ADDR_W-1:0] wr_addr;
    } nbr_req_t;

    function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PATH_MOD})
            s = s - {1'b0, PATH_MOD};
        return s[CNT_W-1:0];
    endfunction

endpackage

### rtl/gepc_start_if.sv
interface gepc_start_if import gepc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] start_row;
    logic [IDX_W-1:0] start_col;

    modport source (output valid, output start_row, output start_col, input ready);
    modport sink (input valid, input start_row, input start_col, output ready);
endinterface

### rtl/gepc_count_if.sv
interface gepc_count_if import gepc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] path_count;

    modport source (output valid, output path_count, input ready);
    modport sink (input valid, input path_count, output ready);
endinterface

### rtl/gepc_layer_ram.sv
module gepc_layer_ram #(
    parameter int DATA_W = 30,
    parameter int ADDR_W = 13
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### rtl/gepc_cell_adder.sv
module gepc_cell_adder import gepc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  nbr_req_t          req,
    input  logic [CNT_W-1:0]  rd_data_a,
    input  logic [CNT_W-1:0]  rd_data_b,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [CNT_W-1:0]  wr_data,
    output logic [CNT_W-1:0]  count
);

    nbr_req_t          req_reg;
    logic [CNT_W-1:0]  ud_reg;
    logic [CNT_W-1:0]  lr_reg;
    logic              wr_pend_reg;
    logic              hit_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [CNT_W-1:0]  res_reg;

    logic [CNT_W-1:0] val_a;
    logic [CNT_W-1:0] val_b;
    logic [CNT_W-1:0] pair;
    logic [CNT_W-1:0] total;

    // off-grid neighbor counts one, the layer before the first is all zero
    always_comb
    begin
        if (!req_reg.on_a)
            val_a = CNT_W'(1);
        else if (req_reg.zero_prev)
            val_a = '0;
        else
            val_a = rd_data_a;
        if (!req_reg.on_b)
            val_b = CNT_W'(1);
        else if (req_reg.zero_prev)
            val_b = '0;
        else
            val_b = rd_data_b;
        pair  = mod_add(val_a, val_b);
        total = mod_add(ud_reg, lr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            req_reg     <= req;
            wr_pend_reg <= req_reg.second;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_reg.first)
        begin
            ud_reg <= pair;
        end
        if (req_reg.second)
        begin
            lr_reg      <= pair;
            hit_reg     <= req_reg.hit;
            wr_addr_reg <= req_reg.wr_addr;
        end
        if (clear)
        begin
            res_reg <= '0;
        end
        else if (wr_pend_reg && hit_reg)
        begin
            res_reg <= total;
        end
    end

    assign wr_en   = wr_pend_reg;
    assign wr_addr = wr_addr_reg;
    assign wr_data = total;
    assign count   = res_reg;

endmodule

### rtl/gepc_sequencer.sv
module gepc_sequencer import gepc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DIM_W-1:0]  rows,
    input  logic [DIM_W-1:0]  cols,
    input  logic [MOVE_W-1:0] moves,
    gepc_start_if.sink        start,
    gepc_count_if.source      result,
    input  logic [CNT_W-1:0]  count,
    output logic              clear,
    output nbr_req_t          req,
    output logic [ADDR_W-1:0] rd_addr_a,
    output logic [ADDR_W-1:0] rd_addr_b
);

    seq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic              phase_reg, phase_next;
    logic [MOVE_W-1:0] layer_reg, layer_next;
    logic [1:0]        drain_reg, drain_next;
    logic [IDX_W-1:0]  srow_reg, srow_next;
    logic [IDX_W-1:0]  scol_reg, scol_next;
    logic              outside_reg, outside_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic             accept;
    logic             prev_par;
    logic             last_row;
    logic             last_col;
    logic [IDX_W-1:0] row_up, row_dn, col_lt, col_rt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= 1'b0;
            layer_reg     <= '0;
            drain_reg     <= '0;
            outside_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            layer_reg     <= layer_next;
            drain_reg     <= drain_next;
            outside_reg   <= outside_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        srow_reg      <= srow_next;
        scol_reg      <= scol_next;
        out_count_reg <= out_count_next;
    end

    assign accept   = start.valid && start.ready;
    assign clear    = accept;
    assign prev_par = ~layer_reg[0];
    assign last_row = ({1'b0, row_reg} + DIM_W'(1)) == rows;
    assign last_col = ({1'b0, col_reg} + DIM_W'(1)) == cols;
    assign row_up   = row_reg - IDX_W'(1);
    assign row_dn   = row_reg + IDX_W'(1);
    assign col_lt   = col_reg - IDX_W'(1);
    assign col_rt   = col_reg + IDX_W'(1);

    // neighbor reads: first half up and down, second half left and right
    always_comb
    begin
        req           = '0;
        req.zero_prev = layer_reg == MOVE_W'(1);
        req.hit       = (row_reg == srow_reg) && (col_reg == scol_reg);
        req.wr_addr   = {layer_reg[0], row_reg, col_reg};
        if (!phase_reg)
        begin
            rd_addr_a = {prev_par, row_up, col_reg};
            rd_addr_b = {prev_par, row_dn, col_reg};
            req.on_a  = row_reg != '0;
            req.on_b  = !last_row;
        end
        else
        begin
            rd_addr_a = {prev_par, row_reg, col_lt};
            rd_addr_b = {prev_par, row_reg, col_rt};
            req.on_a  = col_reg != '0;
            req.on_b  = !last_col;
        end
        if (state_reg == ST_SWEEP)
        begin
            req.first  = !phase_reg;
            req.second = phase_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        layer_next     = layer_reg;
        drain_next     = drain_reg;
        srow_next      = srow_reg;
        scol_next      = scol_reg;
        outside_next   = outside_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        start.ready    = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                start.ready = 1'b1;
                if (start.valid)
                begin
                    srow_next    = start.start_row;
                    scol_next    = start.start_col;
                    outside_next = ({1'b0, start.start_row} >= rows) ||
                                   ({1'b0, start.start_col} >= cols);
                    row_next     = '0;
                    col_next     = '0;
                    phase_next   = 1'b0;
                    layer_next   = MOVE_W'(1);
                    if (outside_next || moves == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                phase_next = ~phase_reg;
                if (phase_reg)
                begin
                    if (last_col)
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            row_next   = '0;
                            drain_next = '0;
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            row_next = row_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == DRAIN_LAST)
                begin
                    if (layer_reg == moves)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        layer_next = layer_reg + MOVE_W'(1);
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = outside_reg ? CNT_W'(1) : count;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.valid      = out_valid_reg;
    assign result.path_count = out_count_reg;

endmodule

### rtl/grid_exit_path_counter.sv
// counts the 4-neighbor walks of at most move_limit steps that leave a
// grid_rows by grid_cols grid from a start cell, modulo 1000000007.
// start channel: one item per query (start_row, start_col); result channel:
// one path_count item per query, in order.
// configuration is a plain write port (cfg_write, cfg_index, cfg_data) and must be
// written only while no query is in flight; the block itself does not enforce this.
// rows, cols and moves saturate at 64. each query sweeps every cell once per move
// layer, reading up and down and then left and right for each cell since the layer
// ram has two read ports and a cell needs four neighbors, plus a drain per layer.
// a start cell off the grid, or a zero move limit, skips the sweep and goes
// straight to loading its count.
// one query is worked at a time; a new item is taken once the sweep is done,
// even while the previous count still sits in the output register.
// a stalled receiver holds the count and the block waits before loading the
// next one. reset returns to idle with rows 1, cols 1 and move limit 0; the
// layer ram is not cleared since each layer is written before it is read.
module grid_exit_path_counter import gepc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    gepc_start_if.sink           start,
    gepc_count_if.source         result
);

    logic [CFG_W-1:0] grid_rows_reg;
    logic [CFG_W-1:0] grid_cols_reg;
    logic [CFG_W-1:0] move_limit_reg;

    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [MOVE_W-1:0] moves;

    logic              clear;
    nbr_req_t          req;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [CNT_W-1:0]  rd_data_a, rd_data_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
    logic [CNT_W-1:0]  count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg  <= CFG_W'(1);
            grid_cols_reg  <= CFG_W'(1);
            move_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROWS:  grid_rows_reg  <= cfg_data;
                CFG_COLS:  grid_cols_reg  <= cfg_data;
                CFG_MOVES: move_limit_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign rows  = (grid_rows_reg > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                     : DIM_W'(grid_rows_reg);
    assign cols  = (grid_cols_reg > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                     : DIM_W'(grid_cols_reg);
    assign moves = (move_limit_reg > CFG_W'(MAX_MOVES)) ? MOVE_W'(MAX_MOVES)
                                                        : MOVE_W'(move_limit_reg);

    gepc_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows      (rows),
        .cols      (cols),
        .moves     (moves),
        .start     (start),
        .result    (result),
        .count     (count),
        .clear     (clear),
        .req       (req),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b)
    );

    gepc_layer_ram #(
        .DATA_W (CNT_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    gepc_cell_adder u_add (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .req       (req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .count     (count)
    );

endmodule

### rtl/gepc_checker.sv
module gepc_checker import gepc_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CNT_W-1:0] path_count
);

    // a held count keeps its value until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(path_count))
        else $error("result item changed while stalled");

    // counts are always reduced
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> path_count < PATH_MOD)
        else $error("path count not reduced");

    // one query at a time: an accepted start leaves the block busy next cycle
    a_one_query: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("start item accepted back to back");

    // a count is loaded only while the start channel is held off
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("count loaded while start channel was open");

endmodule

bind grid_exit_path_counter gepc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start.valid),
    .in_ready   (start.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .path_count (result.path_count)
);

### sim/path_count_checker.sv
`timescale 1ns / 100ps

module path_count_checker import gepc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    gepc_start_if                start_mon,
    gepc_count_if                count_mon,
    output int                   mismatches,
    output int                   counts_seen,
    output int                   pending
);

    logic [CFG_W-1:0] grid_rows_q;
    logic [CFG_W-1:0] grid_cols_q;
    logic [CFG_W-1:0] move_limit_q;
    logic [CNT_W-1:0] count_q [$];
    logic [CNT_W-1:0] want;

    function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        longint unsigned s;
        s = (longint'(a) + longint'(b)) % longint'(PATH_MOD);
        return CNT_W'(s);
    endfunction

    // layer by layer: a cell sums its four neighbors of the layer before,
    // a neighbor off the grid counts as one finished walk
    function automatic logic [CNT_W-1:0] exit_walks(input logic [CFG_W-1:0] rows_cfg,
                                                    input logic [CFG_W-1:0] cols_cfg,
                                                    input logic [CFG_W-1:0] moves_cfg,
                                                    input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        logic [CNT_W-1:0] layer [2][MAX_DIM][MAX_DIM];
        logic [CNT_W-1:0] acc;
        int dr [4] = '{-1, 0, 1, 0};
        int dc [4] = '{0, 1, 0, -1};
        int rows, cols, moves, prv, cur, nr, nc;
        rows  = (rows_cfg > MAX_DIM) ? MAX_DIM : int'(rows_cfg);
        cols  = (cols_cfg > MAX_DIM) ? MAX_DIM : int'(cols_cfg);
        moves = (moves_cfg > MAX_MOVES) ? MAX_MOVES : int'(moves_cfg);
        if (int'(row) >= rows || int'(col) >= cols)
            return CNT_W'(1);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                layer[0][r][c] = '0;
        prv = 0;
        for (int k = 1; k <= moves; k++)
        begin
            cur = 1 - prv;
            for (int r = 0; r < rows; r++)
            begin
                for (int c = 0; c < cols; c++)
                begin
                    acc = '0;
                    for (int d = 0; d < 4; d++)
                    begin
                        nr = r + dr[d];
                        nc = c + dc[d];
                        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols)
                            acc = add_mod(acc, CNT_W'(1));
                        else
                            acc = add_mod(acc, layer[prv][nr][nc]);
                    end
                    layer[cur][r][c] = acc;
                end
            end
            prv = cur;
        end
        return layer[prv][row][col];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%t  mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_q  = CFG_W'(1);
            grid_cols_q  = CFG_W'(1);
            move_limit_q = '0;
            mismatches   = 0;
            counts_seen  = 0;
            pending      = 0;
            count_q.delete();
        end
        else
        begin
            // a start taken on the same edge as a write still sees the old grid
            if (start_mon.valid && start_mon.ready)
                count_q.insert(count_q.size(),
                               exit_walks(grid_rows_q, grid_cols_q, move_limit_q,
                                          start_mon.start_row, start_mon.start_col));
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ROWS:  grid_rows_q  = cfg_data;
                    CFG_COLS:  grid_cols_q  = cfg_data;
                    CFG_MOVES: move_limit_q = cfg_data;
                    default:   ;
                endcase
            end
            if (count_mon.valid && count_mon.ready)
            begin
                counts_seen++;
                if (count_q.size() == 0)
                    report_mismatch($sformatf("count %0d arrived with no start cell waiting",
                                              count_mon.path_count));
                else
                begin
                    want = count_q.pop_front();
                    if (count_mon.path_count !== want)
                        report_mismatch($sformatf("count #%0d path_count %0d, predicted %0d",
                                                  counts_seen, count_mon.path_count, want));
                end
            end
            pending = count_q.size();
        end
    end

endmodule

### sim/grid_exit_path_counter_test.sv
`timescale 1ns / 100ps

module grid_exit_path_counter_test;
    import gepc_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_ITEMS   = 80;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    gepc_start_if start_ch ();
    gepc_count_if count_ch ();

    int mismatches;
    int counts_seen;
    int pending;
    int cells_sent    = 0;
    int off_grid_sent = 0;
    int grids_used    = 1;
    int idle_cycles   = 0;
    int eff_rows      = 1;
    int eff_cols      = 1;
    bit calm          = 1'b0;

    always #10 clk = ~clk;

    grid_exit_path_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start_ch),
        .result    (count_ch)
    );

    path_count_checker count_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_mon   (start_ch),
        .count_mon   (count_ch),
        .mismatches  (mismatches),
        .counts_seen (counts_seen),
        .pending     (pending)
    );

    task automatic program_grid(input int rows, input int cols, input int moves,
                                input bit poke_spare);
        cfg_write <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_data  <= CFG_W'(rows);
        @(posedge clk);
        cfg_index <= CFG_COLS;
        cfg_data  <= CFG_W'(cols);
        @(posedge clk);
        cfg_index <= CFG_MOVES;
        cfg_data  <= CFG_W'(moves);
        @(posedge clk);
        if (poke_spare)
        begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= CFG_W'($urandom);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        eff_rows = (rows > MAX_DIM) ? MAX_DIM : rows;
        eff_cols = (cols > MAX_DIM) ? MAX_DIM : cols;
        grids_used++;
    endtask

    // valid stays high into the next item when no gap is drawn
    task automatic send_start(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
        int gap;
        gap = calm ? 0 : $urandom_range(9);
        if (gap > 0)
        begin
            start_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start_ch.valid     <= 1'b1;
        start_ch.start_row <= row;
        start_ch.start_col <= col;
        do
            @(posedge clk);
        while (!(start_ch.valid && start_ch.ready));
        cells_sent++;
        if (int'(row) >= eff_rows || int'(col) >= eff_cols)
            off_grid_sent++;
    endtask

    task automatic finish_phase();
        start_ch.valid <= 1'b0;
        while (counts_seen < cells_sent)
            @(posedge clk);
    endtask

    initial
    begin : count_drain
        int gap;
        count_ch.ready = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            gap = calm ? 0 : $urandom_range(9);
            if (gap > 0)
            begin
                count_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            count_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(count_ch.valid && count_ch.ready));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (start_ch.valid && start_ch.ready)
                || (count_ch.valid && count_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int r, c, m, n, pick, random_sent;
        logic [IDX_W-1:0] row, col;
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = CFG_ROWS;
        cfg_data           = '0;
        start_ch.valid     = 1'b0;
        start_ch.start_row = '0;
        start_ch.start_col = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid is 1x1 with no moves: inside gives 0, outside gives 1
        send_start(0, 0);
        send_start(63, 63);
        finish_phase();
        program_grid(1, 1, 1, 1'b1);
        send_start(0, 0);
        send_start(0, 1);
        finish_phase();
        // empty grids
        program_grid(0, 5, 3, 1'b0);
        send_start(0, 0);
        send_start(0, 4);
        finish_phase();
        program_grid(3, 0, 127, 1'b0);
        send_start(1, 1);
        finish_phase();
        // oversized dimensions saturate to the full grid
        calm = 1'b1;
        program_grid(127, 100, 2, 1'b1);
        send_start(0, 0);
        send_start(63, 63);
        send_start(32, 17);
        finish_phase();
        calm = 1'b0;
        program_grid(1, 1, 127, 1'b0);
        send_start(0, 0);
        finish_phase();
        program_grid(2, 64, 64, 1'b0);
        send_start(0, 0);
        send_start(1, 63);
        send_start(2, 0);
        finish_phase();
        program_grid(64, 64, 8, 1'b0);
        send_start(31, 31);
        finish_phase();
        program_grid(5, 5, 0, 1'b0);
        send_start(2, 2);
        send_start(5, 0);
        finish_phase();
        program_grid(64, 1, 65, 1'b0);
        send_start(63, 0);
        finish_phase();

        // small grids mostly, now and then one long thin strip
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(7);
            if (pick == 0)
            begin
                r = $urandom_range(65, 127);
                c = $urandom_range(1, 3);
                m = $urandom_range(6);
            end
            else if (pick == 1)
            begin
                r = $urandom_range(1, 3);
                c = $urandom_range(64, 127);
                m = $urandom_range(6);
            end
            else
            begin
                r = $urandom_range(9);
                c = $urandom_range(9);
                m = $urandom_range(24);
            end
            calm = ($urandom_range(3) == 0);
            program_grid(r, c, m, bit'($urandom_range(1)));
            n = $urandom_range(4, 12);
            repeat (n)
            begin
                if ($urandom_range(4) == 0 || eff_rows == 0 || eff_cols == 0)
                begin
                    row = IDX_W'($urandom);
                    col = IDX_W'($urandom);
                end
                else
                begin
                    row = IDX_W'($urandom_range(eff_rows - 1));
                    col = IDX_W'($urandom_range(eff_cols - 1));
                end
                send_start(row, col);
            end
            random_sent += n;
            finish_phase();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d start cells (%0d off the grid) over %0d grid settings",
                 cells_sent, off_grid_sent, grids_used);
        $display("%0d path counts checked, %0d left waiting", counts_seen, pending);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
